>>> design/midi_track_event_parser_macros.svh
// Assertion macros used by the checker file of the track event parser.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define MTEP_ASSERT_NOW(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MTEP_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mtep_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
	localparam logic [2:0] KIND_TEXT_START = 3'd2;
	localparam logic [2:0] KIND_TEXT_BYTE  = 3'd3;
	localparam logic [2:0] KIND_TEMPO      = 3'd4;
	localparam logic [2:0] KIND_TIME_SIG   = 3'd5;
	localparam logic [2:0] KIND_END        = 3'd6;

	// Saturation value of a variable-length quantity.
	localparam logic [27:0] VLQ_MAX28 = 28'h0FF_FFFF | 28'hF00_0000;

	// One input byte of the track body.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} item_t;

	// One reported event.
	typedef struct packed {
		logic [2:0]  kind;
		logic [27:0] delta_time;
		logic [3:0]  channel;
		logic [7:0]  data_a;
		logic [7:0]  data_b;
		logic [7:0]  data_c;
		logic [7:0]  data_d;
		logic [23:0] tempo_us;
		logic [27:0] text_length;
		logic        text_last;
	} result_t;

	// Compact event record passed from the parser to the formatter.
	// The word holds the text length, the tempo or the raw time signature bytes.
	typedef struct packed {
		logic [2:0]  kind;
		logic [27:0] delta_time;
		logic [3:0]  channel;
		logic [7:0]  data_a;
		logic [7:0]  data_b;
		logic [31:0] word;
		logic        text_last;
	} rec_t;

endpackage

>>> design/mtep_front.sv
// Byte parser of the track event parser: decodes delta times, status bytes and
// event data, and emits one compact record per reported event. Uses mtep_pkg.
`timescale 1ns / 1ps

module mtep_front #(
	parameter int VLQ_MAX_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  mtep_pkg::item_t item,
	output logic           rec_valid,
	output mtep_pkg::rec_t rec
);

	localparam logic [3:0] PH_DELTA    = 4'd0;
	localparam logic [3:0] PH_STATUS   = 4'd1;
	localparam logic [3:0] PH_NOTE_KEY = 4'd2;
	localparam logic [3:0] PH_NOTE_VEL = 4'd3;
	localparam logic [3:0] PH_SKIP     = 4'd4;
	localparam logic [3:0] PH_META_TYP = 4'd5;
	localparam logic [3:0] PH_META_LEN = 4'd6;
	localparam logic [3:0] PH_TEXT     = 4'd7;
	localparam logic [3:0] PH_TEMPO    = 4'd8;
	localparam logic [3:0] PH_TSIG     = 4'd9;
	localparam logic [3:0] PH_SYX_LEN  = 4'd10;
	localparam logic [3:0] PH_DONE     = 4'd11;

	localparam logic [7:0] META_END   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_TSIG  = 8'h58;
	localparam logic [27:0] LEN_TEMPO = 28'd3;
	localparam logic [27:0] LEN_TSIG  = 28'd4;
	localparam logic [2:0] VLQ_LIMIT  = 3'(VLQ_MAX_BYTES);
	localparam logic [2:0] VLQ_CNT_TOP = 3'd7;

	logic [3:0]  phase_q;
	logic [27:0] delta_q;
	logic [2:0]  vlq_cnt_q;
	logic [7:0]  status_q;
	logic [7:0]  meta_q;
	logic [27:0] remain_q;
	logic [31:0] payload_q;
	logic        done_q;

	logic [3:0]  cur_phase,   nxt_phase;
	logic [27:0] cur_delta,   nxt_delta;
	logic [2:0]  cur_vlq,     nxt_vlq;
	logic [7:0]  cur_status,  nxt_status;
	logic [7:0]  cur_meta,    nxt_meta;
	logic [27:0] cur_remain,  nxt_remain;
	logic [31:0] cur_payload, nxt_payload;
	logic        cur_done,    nxt_done;

	logic [7:0]  b;
	logic [27:0] vlq_src;
	logic [27:0] vlq_val;
	logic        vlq_end;
	logic [2:0]  vlq_inc;
	logic [27:0] rem_dec;
	logic [31:0] pay_shift;
	logic        do_finish;

	// Next-state logic: a restart clears the state before the byte is parsed.
	always_comb begin
		b = item.data_byte;
		if (item.restart) begin
			cur_phase   = PH_DELTA;
			cur_delta   = '0;
			cur_vlq     = '0;
			cur_status  = '0;
			cur_meta    = '0;
			cur_remain  = '0;
			cur_payload = '0;
			cur_done    = 1'b0;
		end else begin
			cur_phase   = phase_q;
			cur_delta   = delta_q;
			cur_vlq     = vlq_cnt_q;
			cur_status  = status_q;
			cur_meta    = meta_q;
			cur_remain  = remain_q;
			cur_payload = payload_q;
			cur_done    = done_q;
		end

		// Shared variable-length quantity step, on the delta or on a length.
		vlq_src = (cur_phase == PH_DELTA) ? cur_delta : cur_remain;
		if ((cur_vlq >= VLQ_LIMIT) || (vlq_src[27:21] != 7'd0)) begin
			vlq_val = mtep_pkg::VLQ_MAX28;
		end else begin
			vlq_val = {vlq_src[20:0], b[6:0]};
		end
		vlq_end = ~b[7];
		vlq_inc = (cur_vlq == VLQ_CNT_TOP) ? cur_vlq : cur_vlq + 3'd1;

		rem_dec   = (cur_remain == 28'd0) ? cur_remain : cur_remain - 28'd1;
		pay_shift = {cur_payload[23:0], b};

		nxt_phase   = cur_phase;
		nxt_delta   = cur_delta;
		nxt_vlq     = cur_vlq;
		nxt_status  = cur_status;
		nxt_meta    = cur_meta;
		nxt_remain  = cur_remain;
		nxt_payload = cur_payload;
		nxt_done    = cur_done;
		do_finish   = 1'b0;

		rec_valid      = 1'b0;
		rec            = '0;
		rec.delta_time = cur_delta;

		if (!cur_done) begin
			unique case (cur_phase)
				PH_DELTA: begin
					nxt_delta = vlq_val;
					nxt_vlq   = vlq_inc;
					if (vlq_end) begin
						nxt_vlq   = '0;
						nxt_phase = PH_STATUS;
					end
				end
				PH_STATUS: begin
					nxt_status = b;
					unique case (b[7:4]) inside
						4'h8, 4'h9: nxt_phase = PH_NOTE_KEY;
						4'hA, 4'hB, 4'hE: begin
							nxt_remain = 28'd2;
							nxt_phase  = PH_SKIP;
						end
						4'hC, 4'hD: begin
							nxt_remain = 28'd1;
							nxt_phase  = PH_SKIP;
						end
						4'hF: begin
							unique case (b[3:0]) inside
								4'hF: nxt_phase = PH_META_TYP;
								4'h0, 4'h7: begin
									nxt_remain = '0;
									nxt_vlq    = '0;
									nxt_phase  = PH_SYX_LEN;
								end
								4'h2: begin
									nxt_remain = 28'd2;
									nxt_phase  = PH_SKIP;
								end
								4'h1, 4'h3: begin
									nxt_remain = 28'd1;
									nxt_phase  = PH_SKIP;
								end
								default: do_finish = 1'b1;
							endcase
						end
						default: do_finish = 1'b1;
					endcase
				end
				PH_NOTE_KEY: begin
					nxt_payload = {24'd0, b};
					nxt_phase   = PH_NOTE_VEL;
				end
				PH_NOTE_VEL: begin
					rec_valid   = 1'b1;
					rec.kind    = (cur_status[7:4] == 4'h9) ? mtep_pkg::KIND_NOTE_ON
						: mtep_pkg::KIND_NOTE_OFF;
					rec.channel = cur_status[3:0];
					rec.data_a  = cur_payload[7:0];
					rec.data_b  = b;
					do_finish   = 1'b1;
				end
				PH_SKIP: begin
					nxt_remain = rem_dec;
					do_finish  = (rem_dec == 28'd0);
				end
				PH_META_TYP: begin
					nxt_meta   = b;
					nxt_remain = '0;
					nxt_vlq    = '0;
					nxt_phase  = PH_META_LEN;
				end
				PH_META_LEN: begin
					nxt_remain = vlq_val;
					nxt_vlq    = vlq_inc;
					if (vlq_end) begin
						nxt_vlq = '0;
						if ((cur_meta >= 8'd1) && (cur_meta <= 8'd7)) begin
							rec_valid = 1'b1;
							rec.kind  = mtep_pkg::KIND_TEXT_START;
							rec.data_a = cur_meta;
							rec.word  = {4'd0, vlq_val};
							if (vlq_val == 28'd0) begin
								do_finish = 1'b1;
							end else begin
								nxt_phase = PH_TEXT;
							end
						end else if ((cur_meta == META_END) && (vlq_val == 28'd0)) begin
							rec_valid = 1'b1;
							rec.kind  = mtep_pkg::KIND_END;
							nxt_done  = 1'b1;
							nxt_phase = PH_DONE;
						end else begin
							nxt_payload = '0;
							if ((cur_meta == META_TEMPO) && (vlq_val == LEN_TEMPO)) begin
								nxt_phase = PH_TEMPO;
							end else if ((cur_meta == META_TSIG) && (vlq_val == LEN_TSIG)) begin
								nxt_phase = PH_TSIG;
							end else begin
								nxt_phase = PH_SKIP;
								do_finish = (vlq_val == 28'd0);
							end
						end
					end
				end
				PH_TEXT: begin
					nxt_remain     = rem_dec;
					rec_valid      = 1'b1;
					rec.kind       = mtep_pkg::KIND_TEXT_BYTE;
					rec.data_a     = b;
					rec.text_last  = (rem_dec == 28'd0);
					do_finish      = (rem_dec == 28'd0);
				end
				PH_TEMPO, PH_TSIG: begin
					nxt_payload = pay_shift;
					nxt_remain  = rem_dec;
					if (rem_dec == 28'd0) begin
						rec_valid = 1'b1;
						rec.kind  = (cur_phase == PH_TEMPO) ? mtep_pkg::KIND_TEMPO
							: mtep_pkg::KIND_TIME_SIG;
						rec.word  = pay_shift;
						do_finish = 1'b1;
					end
				end
				PH_SYX_LEN: begin
					nxt_remain = vlq_val;
					nxt_vlq    = vlq_inc;
					if (vlq_end) begin
						nxt_vlq   = '0;
						nxt_phase = PH_SKIP;
						do_finish = (vlq_val == 28'd0);
					end
				end
				PH_DONE: begin
					nxt_phase = PH_DONE;
				end
				default: do_finish = 1'b1;
			endcase
		end

		// End of an event: back to waiting for the next delta time.
		if (do_finish) begin
			nxt_phase   = PH_DELTA;
			nxt_delta   = '0;
			nxt_vlq     = '0;
			nxt_remain  = '0;
			nxt_payload = '0;
		end
	end

	// Parser state registers, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DELTA;
			delta_q   <= '0;
			vlq_cnt_q <= '0;
			status_q  <= '0;
			meta_q    <= '0;
			remain_q  <= '0;
			payload_q <= '0;
			done_q    <= 1'b0;
		end else if (take) begin
			phase_q   <= nxt_phase;
			delta_q   <= nxt_delta;
			vlq_cnt_q <= nxt_vlq;
			status_q  <= nxt_status;
			meta_q    <= nxt_meta;
			remain_q  <= nxt_remain;
			payload_q <= nxt_payload;
			done_q    <= nxt_done;
		end
	end

endmodule

>>> design/mtep_queue.sv
// Short record queue between the parser and the formatter.
// Uses mtep_pkg for the record type.
`timescale 1ns / 1ps

module mtep_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mtep_pkg::rec_t wr_data,
	input  logic           rd_en,
	output mtep_pkg::rec_t rd_data,
	output logic           not_empty,
	output logic           full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	mtep_pkg::rec_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_data   = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/mtep_back.sv
// Result formatter: expands queued records into full results and holds the
// oldest one in the output register. Uses mtep_pkg.
`timescale 1ns / 1ps

module mtep_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_avail,
	input  mtep_pkg::rec_t   rec,
	output logic             rec_take,
	output logic             empty,
	input  logic             pop,
	output mtep_pkg::result_t result
);

	mtep_pkg::result_t fmt;
	mtep_pkg::result_t result_q;
	logic              valid_q;
	logic [7:0]        den_exp;

	// Load the register whenever it is free or being emptied this cycle.
	assign rec_take = rec_avail && (!valid_q || pop);
	assign empty    = !valid_q;
	assign result   = result_q;

	// Field layout per kind; unused fields stay zero.
	always_comb begin
		den_exp        = rec.word[23:16];
		fmt            = '0;
		fmt.kind       = rec.kind;
		fmt.delta_time = rec.delta_time;
		fmt.channel    = rec.channel;
		fmt.text_last  = rec.text_last;
		unique case (rec.kind)
			mtep_pkg::KIND_TEMPO: begin
				fmt.tempo_us = rec.word[23:0];
			end
			mtep_pkg::KIND_TIME_SIG: begin
				fmt.data_a = rec.word[31:24];
				fmt.data_b = (den_exp[7:3] == 5'd0) ? (8'd1 << den_exp[2:0]) : 8'd0;
				fmt.data_c = rec.word[15:8];
				fmt.data_d = rec.word[7:0];
			end
			mtep_pkg::KIND_TEXT_START: begin
				fmt.data_a      = rec.data_a;
				fmt.text_length = rec.word[27:0];
			end
			default: begin
				fmt.data_a = rec.data_a;
				fmt.data_b = rec.data_b;
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (rec_take) begin
			result_q <= fmt;
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

>>> design/midi_track_event_parser.sv
// Top level of the MIDI track event parser: parser, record queue and formatter.
// Depends on mtep_pkg, mtep_front, mtep_queue and mtep_back.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------
//  item     | push / full        | mtep_pkg::item_t (byte, restart)
//  result   | empty / pop        | mtep_pkg::result_t (one event)
//
// One byte is accepted per cycle while the record queue is not full; each byte
// is parsed in the cycle it arrives. The record of a result is written into the
// record queue and then loaded into the output register once that is free.
// Reset clears the parser state and empties the queue and the output register.
// full rises only while QUEUE_DEPTH records wait behind an unread result.
`timescale 1ns / 1ps

module midi_track_event_parser #(
	parameter int VLQ_MAX_BYTES = 4,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mtep_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output mtep_pkg::result_t result
);

	logic           take;
	logic           rec_valid;
	mtep_pkg::rec_t rec_in;
	mtep_pkg::rec_t rec_out;
	logic           q_not_empty;
	logic           q_full;
	logic           rec_take;

	// A byte is taken whenever the record queue has room.
	assign take = push && !q_full;
	assign full = q_full;

	mtep_front #(
		.VLQ_MAX_BYTES(VLQ_MAX_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.rec_valid(rec_valid),
		.rec      (rec_in)
	);

	mtep_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take && rec_valid),
		.wr_data  (rec_in),
		.rd_en    (rec_take),
		.rd_data  (rec_out),
		.not_empty(q_not_empty),
		.full     (q_full)
	);

	mtep_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_avail(q_not_empty),
		.rec      (rec_out),
		.rec_take (rec_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> design/mtep_checker.sv
// Port-level checks of the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and midi_track_event_parser_macros.svh.
`timescale 1ns / 1ps
`include "midi_track_event_parser_macros.svh"

module mtep_port_checks (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input mtep_pkg::result_t result
);

	// A waiting result that is not taken stays unchanged.
	`MTEP_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(result), "result changed while waiting")

	// Backpressure only arises when a result sits unread at the output.
	`MTEP_ASSERT_NOW(a_full_needs_result, clk, arst_n, full, !empty, "full without a waiting result")

	// The time signature denominator is a power of two or zero.
	`MTEP_ASSERT_NOW(a_tsig_den, clk, arst_n, !empty && (result.kind == mtep_pkg::KIND_TIME_SIG), $onehot0(result.data_b), "bad time signature denominator")

	// Note events carry no tempo, text length or last flag.
	`MTEP_ASSERT_NOW(a_note_fields, clk, arst_n, !empty && ((result.kind == mtep_pkg::KIND_NOTE_ON) || (result.kind == mtep_pkg::KIND_NOTE_OFF)), (result.tempo_us == '0) && (result.text_length == '0) && !result.text_last, "stray fields on a note event")

endmodule

bind midi_track_event_parser mtep_port_checks u_mtep_port_checks (
	.clk   (clk),
	.arst_n(arst_n),
	.full  (full),
	.empty (empty),
	.pop   (pop),
	.result(result)
);
